// ----- design/ozss_pkg.sv -----
// Shared types and constants for the obstacle zone speed selector.
// Holds the zone codes, the word formats between the parts and the reset values.
// Depends on nothing; every other design file except ozss_fifo refers to it by scoped names.
package ozss_pkg;

	// Configuration port geometry.
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	// Register indexes, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_NEAR_LIMIT   = 2'd0,
		REG_SLOW_LIMIT   = 2'd1,
		REG_SLOW_SPEED   = 2'd2,
		REG_CRUISE_SPEED = 2'd3
	} reg_idx_t;

	// Register reset values.
	localparam logic [7:0] NEAR_LIMIT_RST   = 8'd30;
	localparam logic [7:0] SLOW_LIMIT_RST   = 8'd50;
	localparam logic [6:0] SLOW_SPEED_RST   = 7'd30;
	localparam logic [6:0] CRUISE_SPEED_RST = 7'd70;

	// Stored distances come out of reset as far away as possible.
	localparam logic [7:0] DIST_RST = 8'd255;

	// Speed rule constants, in the 9-bit signed wheel speed format.
	localparam logic signed [8:0] SPIN_BACK   = -9'sd10;
	localparam logic signed [8:0] SIDE_OFFSET = 9'sd20;
	localparam logic signed [8:0] OUT_LIMIT   = 9'sd100;

	// Divide by ten as a multiply by 6554 / 2^16; exact for magnitudes below 2048.
	localparam logic [12:0] RECIP_DIV10 = 13'd6554;

	// Default queue depths.
	localparam int unsigned CMD_DEPTH_DEF = 2;
	localparam int unsigned RES_DEPTH_DEF = 2;

	typedef enum logic [1:0] {
		ZONE_NEAR  = 2'd0,
		ZONE_SLOW  = 2'd1,
		ZONE_CLEAR = 2'd2
	} zone_t;

	typedef struct packed {
		logic [7:0] near_limit;
		logic [7:0] slow_limit;
		logic [6:0] slow_speed;
		logic [6:0] cruise_speed;
	} cfg_t;

	// Classified word handed from the front part to the back part.
	typedef struct packed {
		zone_t      zone_fl;
		zone_t      zone_fr;
		zone_t      zone_sl;
		zone_t      zone_sr;
		logic [7:0] dist_sl;
		logic [7:0] dist_sr;
	} cmd_t;

	typedef struct packed {
		logic signed [7:0] left_speed;
		logic signed [7:0] right_speed;
	} res_t;

endpackage

// ----- design/ozss_fifo.sv -----
// Small first-in first-out queue of packed words with full and empty flags.
// Used between the front and back parts and for the result words.
// Depends on nothing outside itself.
module ozss_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/ozss_cfg.sv -----
// Configuration register file behind an APB-style port.
// Holds the zone limits and the slow and cruise speeds; uses ozss_pkg.
// The user must write the registers only while the block is idle; the block itself does not enforce this.
module ozss_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ozss_pkg::ADDR_W-1:0] paddr,
	input  logic [ozss_pkg::DATA_W-1:0] pwdata,
	output logic [ozss_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output ozss_pkg::cfg_t              cfg
);

	ozss_pkg::cfg_t     cfg_q;
	ozss_pkg::reg_idx_t idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = ozss_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_limit   <= ozss_pkg::NEAR_LIMIT_RST;
			cfg_q.slow_limit   <= ozss_pkg::SLOW_LIMIT_RST;
			cfg_q.slow_speed   <= ozss_pkg::SLOW_SPEED_RST;
			cfg_q.cruise_speed <= ozss_pkg::CRUISE_SPEED_RST;
		end else if (wr_en) begin
			case (idx)
				ozss_pkg::REG_NEAR_LIMIT:   cfg_q.near_limit   <= pwdata[7:0];
				ozss_pkg::REG_SLOW_LIMIT:   cfg_q.slow_limit   <= pwdata[7:0];
				ozss_pkg::REG_SLOW_SPEED:   cfg_q.slow_speed   <= pwdata[6:0];
				ozss_pkg::REG_CRUISE_SPEED: cfg_q.cruise_speed <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			ozss_pkg::REG_NEAR_LIMIT:   prdata = {24'd0, cfg_q.near_limit};
			ozss_pkg::REG_SLOW_LIMIT:   prdata = {24'd0, cfg_q.slow_limit};
			ozss_pkg::REG_SLOW_SPEED:   prdata = {25'd0, cfg_q.slow_speed};
			ozss_pkg::REG_CRUISE_SPEED: prdata = {25'd0, cfg_q.cruise_speed};
			default:                    prdata = '0;
		endcase
	end

endmodule

// ----- design/ozss_front.sv -----
// Front part: stores the four sonar distances and sorts them into zones.
// Emits one classified word per accepted input word; uses ozss_pkg.
module ozss_front (
	input  logic           clk,
	input  logic           arst_n,
	input  ozss_pkg::cfg_t cfg,
	input  logic           accept,
	input  logic           mode,
	input  logic [7:0]     dist_left,
	input  logic [7:0]     dist_right,
	output ozss_pkg::cmd_t cmd
);

	logic [7:0] dist_q [4];
	logic [7:0] dist_nx [4];

	function automatic ozss_pkg::zone_t zone_of(input logic [7:0] d,
	                                            input ozss_pkg::cfg_t c);
		ozss_pkg::zone_t z;
		if (d < c.near_limit) begin
			z = ozss_pkg::ZONE_NEAR;
		end else if (d < c.slow_limit) begin
			z = ozss_pkg::ZONE_SLOW;
		end else begin
			z = ozss_pkg::ZONE_CLEAR;
		end
		return z;
	endfunction

	// The incoming pair replaces the front or the side pair.
	always_comb begin
		dist_nx[0] = mode ? dist_q[0] : dist_left;
		dist_nx[1] = mode ? dist_q[1] : dist_right;
		dist_nx[2] = mode ? dist_left : dist_q[2];
		dist_nx[3] = mode ? dist_right : dist_q[3];
	end

	always_comb begin
		cmd.zone_fl = zone_of(dist_nx[0], cfg);
		cmd.zone_fr = zone_of(dist_nx[1], cfg);
		cmd.zone_sl = zone_of(dist_nx[2], cfg);
		cmd.zone_sr = zone_of(dist_nx[3], cfg);
		cmd.dist_sl = dist_nx[2];
		cmd.dist_sr = dist_nx[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				dist_q[i] <= ozss_pkg::DIST_RST;
			end
		end else if (accept) begin
			for (int i = 0; i < 4; i++) begin
				dist_q[i] <= dist_nx[i];
			end
		end
	end

endmodule

// ----- design/ozss_back.sv -----
// Back part: applies the speed rules to the held wheel speeds.
// Takes classified words, produces saturated result words; uses ozss_pkg.
module ozss_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ozss_pkg::cfg_t cfg,
	input  logic           cmd_valid,
	input  ozss_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  logic           res_full,
	output logic           res_push,
	output ozss_pkg::res_t res
);

	logic signed [8:0] m0_q;
	logic signed [8:0] m1_q;
	logic signed [8:0] m0_nx;
	logic signed [8:0] m1_nx;
	logic signed [8:0] s9;
	logic signed [8:0] t9;
	logic signed [8:0] top;
	logic signed [8:0] third_in;
	logic signed [8:0] third_out;
	logic              fire;
	logic              fl_near;
	logic              fr_near;
	logic              sl_near;
	logic              sr_near;

	// (a+b)/2 truncated toward zero.
	function automatic logic signed [8:0] half_step(input logic signed [8:0] a,
	                                                input logic signed [8:0] b);
		logic [9:0] sum;
		logic [9:0] adj;
		sum = {a[8], a} + {b[8], b};
		adj = sum + {9'd0, sum[9] & sum[0]};
		return adj[9:1];
	endfunction

	function automatic logic signed [7:0] saturate(input logic signed [8:0] v);
		logic signed [7:0] o;
		if (v > ozss_pkg::OUT_LIMIT) begin
			o = 8'(ozss_pkg::OUT_LIMIT);
		end else if (v < -ozss_pkg::OUT_LIMIT) begin
			o = 8'(-ozss_pkg::OUT_LIMIT);
		end else begin
			o = v[7:0];
		end
		return o;
	endfunction

	assign s9      = {2'b00, cfg.slow_speed};
	assign t9      = {2'b00, cfg.cruise_speed};
	assign fire    = cmd_valid && !res_full;
	assign cmd_pop = fire;
	assign fl_near = (cmd.zone_fl == ozss_pkg::ZONE_NEAR);
	assign fr_near = (cmd.zone_fr == ozss_pkg::ZONE_NEAR);
	assign sl_near = (cmd.zone_sl == ozss_pkg::ZONE_NEAR);
	assign sr_near = (cmd.zone_sr == ozss_pkg::ZONE_NEAR);
	assign top     = (m0_q > m1_q) ? m0_q : m1_q;

	// The 0.3 step, (7m+3S)/10 truncated toward zero, is needed on one wheel at most.
	assign third_in = (cmd.zone_fr == ozss_pkg::ZONE_SLOW) ? m1_q : m0_q;

	always_comb begin
		logic [12:0] x;
		logic [12:0] xm;
		logic [12:0] xs;
		logic [12:0] mag;
		logic [23:0] prod;
		logic [8:0]  q;
		xm   = {{4{third_in[8]}}, third_in};
		xs   = {6'd0, cfg.slow_speed};
		x    = (xm << 3) - xm + (xs << 1) + xs;
		mag  = x[12] ? (13'd0 - x) : x;
		prod = 24'(mag[10:0]) * 24'(ozss_pkg::RECIP_DIV10);
		q    = {1'b0, prod[23:16]};
		third_out = x[12] ? (9'd0 - q) : q;
	end

	always_comb begin
		m0_nx = m0_q;
		m1_nx = m1_q;
		if (fl_near && fr_near) begin
			if (sl_near && sr_near) begin
				m0_nx = s9;
				m1_nx = -s9;
			end else begin
				m0_nx = (cmd.dist_sl < cmd.dist_sr) ? s9 : ozss_pkg::SPIN_BACK;
				m1_nx = (cmd.dist_sl > cmd.dist_sr) ? s9 : ozss_pkg::SPIN_BACK;
			end
		end else if (fl_near) begin
			m0_nx = s9;
			m1_nx = ozss_pkg::SPIN_BACK;
		end else if (fr_near) begin
			m0_nx = ozss_pkg::SPIN_BACK;
			m1_nx = s9;
		end else if (cmd.zone_fl == ozss_pkg::ZONE_CLEAR
		             && cmd.zone_fr == ozss_pkg::ZONE_CLEAR) begin
			if (sl_near != sr_near) begin
				m0_nx = sl_near ? s9 : $signed({1'b0, cmd.dist_sl}) - ozss_pkg::SIDE_OFFSET;
				m1_nx = sr_near ? s9 : $signed({1'b0, cmd.dist_sr}) - ozss_pkg::SIDE_OFFSET;
			end else if (top < t9) begin
				m0_nx = half_step(top, t9);
				m1_nx = half_step(top, t9);
			end else begin
				m0_nx = t9;
				m1_nx = t9;
			end
		end else if (cmd.zone_fl == cmd.zone_fr) begin
			m0_nx = half_step(m0_q, s9);
			m1_nx = half_step(m1_q, s9);
		end else if (cmd.zone_fr == ozss_pkg::ZONE_SLOW) begin
			m0_nx = half_step(m0_q, s9);
			m1_nx = third_out;
		end else begin
			m0_nx = third_out;
			m1_nx = half_step(m1_q, s9);
		end
	end

	assign res_push        = fire;
	assign res.left_speed  = saturate(m0_nx);
	assign res.right_speed = saturate(m1_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m0_q <= '0;
			m1_q <= '0;
		end else if (fire) begin
			m0_q <= m0_nx;
			m1_q <= m1_nx;
		end
	end

endmodule

// ----- design/obstacle_zone_speed_select.sv -----
// Obstacle zone speed selector: sonar distance pairs in, left and right motor speeds out.
// An accepted word passes through the classified-word queue and the back part into the result queue.
// Throughput: one word per cycle while the result queue has room, set by the combinational rule stage in the back part.
// Reset (arst_n low, asynchronous): queues empty, distances 255, wheel speeds zero,
// registers at near 30, slow 50, slow speed 30, cruise 70. Depends on ozss_pkg.
module obstacle_zone_speed_select #(
	parameter int unsigned CMD_DEPTH = ozss_pkg::CMD_DEPTH_DEF,
	parameter int unsigned RES_DEPTH = ozss_pkg::RES_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input word queue side.
	input  logic                        push,
	output logic                        full,
	input  logic                        mode,
	input  logic [7:0]                  dist_left,
	input  logic [7:0]                  dist_right,
	// Result word queue side.
	output logic                        empty,
	input  logic                        pop,
	output logic signed [7:0]           left_speed,
	output logic signed [7:0]           right_speed,
	// Configuration port.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ozss_pkg::ADDR_W-1:0] paddr,
	input  logic [ozss_pkg::DATA_W-1:0] pwdata,
	output logic [ozss_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	ozss_pkg::cfg_t cfg;
	ozss_pkg::cmd_t cmd_in;
	ozss_pkg::cmd_t cmd_out;
	ozss_pkg::res_t res_in;
	ozss_pkg::res_t res_out;
	logic           accept;
	logic           cmd_empty;
	logic           cmd_pop;
	logic           res_full;
	logic           res_push;

	// An input word is taken whenever the classified-word queue has room.
	assign accept = push && !full;

	ozss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The front part updates the stored distances and classifies all four
	// in the same cycle that the word is accepted.
	ozss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.accept     (accept),
		.mode       (mode),
		.dist_left  (dist_left),
		.dist_right (dist_right),
		.cmd        (cmd_in)
	);

	// The classified words wait here so that the front keeps accepting while
	// the back is held by a full result queue.
	ozss_fifo #(
		.WIDTH ($bits(ozss_pkg::cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	// The back part applies the speed rules to the held wheel speeds, one classified
	// word per cycle while the result queue has room, and hands over the saturated speeds.
	ozss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Result words wait here until the consumer pops them.
	ozss_fifo #(
		.WIDTH ($bits(ozss_pkg::res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign left_speed  = res_out.left_speed;
	assign right_speed = res_out.right_speed;

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for obstacle_zone_speed_select: a tracker class predicts the wheel speeds.
// Words go in through the push/full queue side, results leave through empty/pop, settings via APB.
// Depends on ozss_pkg and the obstacle_zone_speed_select module.
module tb;

	// Fixed numbers of the speed rules, kept apart from the package on purpose.
	localparam int SPIN_BACK_SPEED = -10;
	localparam int SIDE_CLEARANCE  = 20;
	localparam int DRIVE_LIMIT     = 100;

	// A result word becomes readable once its input word has passed the classified-word queue
	// and the back part; the drain adds a margin.
	localparam int RESULT_LATENCY = 1;
	// The receiver's long hold-off, and the watchdog on cycles with no transfer at all.
	localparam int HOLD_CYCLES   = 300;
	localparam int WATCHDOG_SPAN = 2000;
	localparam int PHASES        = 10;
	localparam int WORDS_PER_PHASE = 100;

	// Tracks the stored distances and wheel speeds and keeps the speed pairs still to come.
	class wheel_speed_tracker;
		logic [7:0] near_lim;
		logic [7:0] slow_lim;
		logic [6:0] slow_spd;
		logic [6:0] cruise_spd;
		logic [7:0] distance[4];
		int wheel[2];
		ozss_pkg::res_t pending[$];
		int errors;

		function new();
			near_lim   = 8'd30;
			slow_lim   = 8'd50;
			slow_spd   = 7'd30;
			cruise_spd = 7'd70;
			foreach (distance[k])
				distance[k] = 8'd255;
			wheel[0] = 0;
			wheel[1] = 0;
			errors = 0;
		endfunction

		function void set_reg(ozss_pkg::reg_idx_t idx, logic [31:0] word);
			case (idx)
				ozss_pkg::REG_NEAR_LIMIT:   near_lim = word[7:0];
				ozss_pkg::REG_SLOW_LIMIT:   slow_lim = word[7:0];
				ozss_pkg::REG_SLOW_SPEED:   slow_spd = word[6:0];
				ozss_pkg::REG_CRUISE_SPEED: cruise_spd = word[6:0];
				default: ;
			endcase
		endfunction

		// Near is judged first, so limits out of order still give a well-defined zone.
		function ozss_pkg::zone_t zone_of(logic [7:0] d);
			if (d < near_lim)
				return ozss_pkg::ZONE_NEAR;
			if (d < slow_lim)
				return ozss_pkg::ZONE_SLOW;
			return ozss_pkg::ZONE_CLEAR;
		endfunction

		// Both steps truncate toward zero, which is what signed int division does.
		function int half_step(int m, int target);
			return (m + target) / 2;
		endfunction

		function int third_step(int m, int target);
			return (7 * m + 3 * target) / 10;
		endfunction

		function logic signed [7:0] clip(int v);
			if (v > DRIVE_LIMIT)
				v = DRIVE_LIMIT;
			if (v < -DRIVE_LIMIT)
				v = -DRIVE_LIMIT;
			return v[7:0];
		endfunction

		function void take_distances(logic side_pair, logic [7:0] d_left, logic [7:0] d_right);
			ozss_pkg::zone_t z[4];
			ozss_pkg::res_t next;
			int s;
			int t;
			int top;
			s = int'(slow_spd);
			t = int'(cruise_spd);
			distance[side_pair ? 2 : 0] = d_left;
			distance[side_pair ? 3 : 1] = d_right;
			foreach (z[k])
				z[k] = zone_of(distance[k]);
			if (z[0] == ozss_pkg::ZONE_NEAR && z[1] == ozss_pkg::ZONE_NEAR) begin
				if (z[2] == ozss_pkg::ZONE_NEAR && z[3] == ozss_pkg::ZONE_NEAR) begin
					wheel[0] = s;
					wheel[1] = -s;
				end else begin
					// Turn away from the nearer side; equal sides back off on both wheels.
					wheel[0] = (distance[2] < distance[3]) ? s : SPIN_BACK_SPEED;
					wheel[1] = (distance[2] > distance[3]) ? s : SPIN_BACK_SPEED;
				end
			end else if (z[0] == ozss_pkg::ZONE_NEAR) begin
				wheel[0] = s;
				wheel[1] = SPIN_BACK_SPEED;
			end else if (z[1] == ozss_pkg::ZONE_NEAR) begin
				wheel[0] = SPIN_BACK_SPEED;
				wheel[1] = s;
			end else if (z[0] == ozss_pkg::ZONE_CLEAR && z[1] == ozss_pkg::ZONE_CLEAR) begin
				top = (wheel[0] > wheel[1]) ? wheel[0] : wheel[1];
				if ((z[2] == ozss_pkg::ZONE_NEAR || z[3] == ozss_pkg::ZONE_NEAR) && z[2] != z[3]) begin
					wheel[0] = (z[2] == ozss_pkg::ZONE_NEAR) ? s : int'(distance[2]) - SIDE_CLEARANCE;
					wheel[1] = (z[3] == ozss_pkg::ZONE_NEAR) ? s : int'(distance[3]) - SIDE_CLEARANCE;
				end else if (top < t) begin
					wheel[0] = half_step(top, t);
					wheel[1] = half_step(top, t);
				end else begin
					wheel[0] = t;
					wheel[1] = t;
				end
			end else if (z[0] == z[1]) begin
				wheel[0] = half_step(wheel[0], s);
				wheel[1] = half_step(wheel[1], s);
			end else if (z[1] == ozss_pkg::ZONE_SLOW) begin
				wheel[1] = third_step(wheel[1], s);
				wheel[0] = half_step(wheel[0], s);
			end else begin
				wheel[1] = half_step(wheel[1], s);
				wheel[0] = third_step(wheel[0], s);
			end
			next.left_speed  = clip(wheel[0]);
			next.right_speed = clip(wheel[1]);
			pending.push_back(next);
		endfunction

		function void check_speeds(logic signed [7:0] left_got, logic signed [7:0] right_got);
			ozss_pkg::res_t want;
			if (pending.size() == 0) begin
				$error("result word with no input word behind it: left_speed %0d, right_speed %0d",
					left_got, right_got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (left_got !== want.left_speed) begin
				$error("left_speed: expected %0d, got %0d", want.left_speed, left_got);
				errors++;
			end
			if (right_got !== want.right_speed) begin
				$error("right_speed: expected %0d, got %0d", want.right_speed, right_got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic mode = 1'b0;
	logic [7:0] dist_left = 8'd0;
	logic [7:0] dist_right = 8'd0;
	logic empty;
	logic pop = 1'b0;
	logic signed [7:0] left_speed;
	logic signed [7:0] right_speed;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ozss_pkg::ADDR_W-1:0] paddr = '0;
	logic [ozss_pkg::DATA_W-1:0] pwdata = '0;
	logic [ozss_pkg::DATA_W-1:0] prdata;
	logic pready;

	// Set by the sender, read by the receiver: quiet turns idling off, hold_rx asks for a hold-off.
	bit quiet = 1'b0;
	bit hold_rx = 1'b0;
	int idle_cycles = 0;

	wheel_speed_tracker tracker = new();

	obstacle_zone_speed_select u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.mode       (mode),
		.dist_left  (dist_left),
		.dist_right (dist_right),
		.empty      (empty),
		.pop        (pop),
		.left_speed (left_speed),
		.right_speed(right_speed),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #6 clk = ~clk;

	// Gap lengths: mostly none or short, now and then a long one; nothing in quiet stretches.
	function automatic int gap_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(99, 0);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(10, 4);
		return $urandom_range(40, 20);
	endfunction

	// Distances are aimed at the zone limits of the current settings so that every
	// zone, and the values right at each limit, show up often.
	function automatic logic [7:0] pick_dist();
		int r;
		int lo;
		int v;
		r = $urandom_range(9, 0);
		v = $urandom_range(255, 0);
		case (r)
			3: v = int'(tracker.near_lim) + $urandom_range(2, 0) - 1;
			4: v = int'(tracker.slow_lim) + $urandom_range(2, 0) - 1;
			5, 6: if (tracker.near_lim != 0)
				v = $urandom_range(int'(tracker.near_lim) - 1, 0);
			7: begin
				lo = int'(tracker.near_lim);
				if (tracker.slow_lim > tracker.near_lim)
					v = $urandom_range(int'(tracker.slow_lim) - 1, lo);
			end
			8, 9: v = $urandom_range(255, int'(tracker.slow_lim));
			default: ;
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	// Offers one word after a random gap and returns at the edge where it is taken.
	// Called at a rising edge; push stays high when the next word follows at once.
	task automatic send_word(input logic side_pair, input logic [7:0] d_left,
		input logic [7:0] d_right);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		mode <= side_pair;
		dist_left <= d_left;
		dist_right <= d_right;
		do
			@(posedge clk);
		while (full);
	endtask

	// Stops sending and waits until every expected word has been read, plus the pipeline depth,
	// so that the block is idle before the settings change.
	task automatic drain();
		push <= 1'b0;
		do
			@(posedge clk);
		while (tracker.pending.size() != 0);
		repeat (RESULT_LATENCY + 1) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register takes the word at the edge
	// that closes the access cycle. Bits above the register width carry random noise.
	// The bus then idles, so that a following write starts on a later edge.
	task automatic write_reg(input ozss_pkg::reg_idx_t idx, input logic [7:0] value);
		logic [31:0] word;
		word = $urandom;
		if (idx == ozss_pkg::REG_NEAR_LIMIT || idx == ozss_pkg::REG_SLOW_LIMIT)
			word[7:0] = value;
		else
			word[6:0] = value[6:0];
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.set_reg(idx, word);
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [7:0] near_v, input logic [7:0] slow_v,
		input logic [6:0] slow_spd_v, input logic [6:0] cruise_v);
		write_reg(ozss_pkg::REG_NEAR_LIMIT, near_v);
		write_reg(ozss_pkg::REG_SLOW_LIMIT, slow_v);
		write_reg(ozss_pkg::REG_SLOW_SPEED, {1'b0, slow_spd_v});
		write_reg(ozss_pkg::REG_CRUISE_SPEED, {1'b0, cruise_v});
	endtask

	// Monitor: every transfer is judged on the values held just before the edge.
	// A result word read at an edge always belongs to an earlier input word, so it is
	// checked before the input word of the same edge is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				tracker.check_speeds(left_speed, right_speed);
			if (push && !full)
				tracker.take_distances(mode, dist_left, dist_right);
		end
	end

	// Watchdog on cycles in which no word moves on either side and no register is written.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_SPAN) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Receiver: random stalls, runs of back-to-back reads in quiet stretches, and one long
	// hold-off counted here when the sender asks for it, so that the block fills and stalls.
	initial begin : result_reader
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
				pop <= 1'b1;
			end else if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				stall = gap_len();
			end
		end
	end

	initial begin : stimulus
		int phase;
		int n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words under the reset settings (near 30, slow 50, slow speed 30, cruise 70).
		// Both front near with far sides that are equal: both wheels back off.
		send_word(1'b0, 8'd5, 8'd5);
		// Both front near, one side near: turn away from it, each way.
		send_word(1'b1, 8'd10, 8'd200);
		send_word(1'b1, 8'd200, 8'd10);
		// Everything near: spin on the spot.
		send_word(1'b1, 8'd0, 8'd0);
		// Front near, sides equal but not near.
		send_word(1'b1, 8'd100, 8'd100);
		// Only one front sensor near, each side.
		send_word(1'b0, 8'd10, 8'd100);
		send_word(1'b0, 8'd100, 8'd10);
		// Clear front: speed climbs by half steps toward cruise.
		send_word(1'b0, 8'd255, 8'd255);
		send_word(1'b0, 8'd255, 8'd255);
		send_word(1'b0, 8'd255, 8'd255);
		send_word(1'b0, 8'd255, 8'd255);
		send_word(1'b0, 8'd255, 8'd255);
		// Clear front with exactly one side near: steer off it; the far side saturates.
		send_word(1'b1, 8'd10, 8'd255);
		send_word(1'b1, 8'd255, 8'd10);
		send_word(1'b1, 8'd255, 8'd255);
		// Both front slow, then one slow and one clear in both orders.
		send_word(1'b0, 8'd40, 8'd40);
		send_word(1'b0, 8'd255, 8'd40);
		send_word(1'b0, 8'd40, 8'd255);
		// Extremes of the front pair and values right at the limits.
		send_word(1'b0, 8'd0, 8'd255);
		send_word(1'b0, 8'd255, 8'd0);
		send_word(1'b0, 8'd30, 8'd50);
		send_word(1'b0, 8'd29, 8'd49);
		drain();

		// Random phases. The first few use extreme settings: limits out of order, everything
		// zero, everything at the top, a small near limit that lets a side offset go negative,
		// and the reset values. The rest draw settings at random.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: apply_settings(8'd200, 8'd50, 7'd127, 7'd127);
				1: apply_settings(8'd0, 8'd0, 7'd0, 7'd0);
				2: apply_settings(8'd255, 8'd255, 7'd100, 7'd100);
				3: apply_settings(8'd5, 8'd60, 7'd45, 7'd90);
				4: apply_settings(8'd30, 8'd50, 7'd30, 7'd70);
				default: apply_settings(8'($urandom_range(120, 0)), 8'($urandom_range(255, 0)),
					7'($urandom_range(127, 0)), 7'($urandom_range(127, 0)));
			endcase
			quiet = (phase % 4 == 2);
			// One phase keeps offering words while the receiver is held off.
			if (phase == 7)
				hold_rx = 1'b1;
			for (n = 0; n < WORDS_PER_PHASE; n++)
				send_word(1'($urandom_range(1, 0)), pick_dist(), pick_dist());
			// The sender pauses here until every expected word has come.
			drain();
		end

		if (tracker.pending.size() != 0) begin
			$error("%0d expected result words never arrived", tracker.pending.size());
			tracker.errors++;
		end
		if (tracker.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
